// ===== hdl/tbot_pkg.sv =====
// Shared types and constants for the triangle / box overlap test pipeline.
// No dependencies; used by every module under hdl/.
package tbot_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int SIZE_W          = 15;
	localparam int DSIGNED_W       = SIZE_W + 1;
	localparam int INDEX_W         = 2;

	typedef enum logic [INDEX_W-1:0] {
		REG_BOX_SIZE_X = 2'd0,
		REG_BOX_SIZE_Y = 2'd1,
		REG_BOX_SIZE_Z = 2'd2
	} reg_index_t;

	// load strobes of pipeline stages s2 to s4, one per stage
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} tbot_ld_t;

endpackage

// ===== hdl/tbot_cross.sv =====
// Triangle normal n = e x f over two stages: products, then differences.
// Depends on tbot_pkg.
module tbot_cross #(
	parameter int CW = tbot_pkg::COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  tbot_pkg::tbot_ld_t       ld,
	input  logic signed [CW:0]       e [3],
	input  logic signed [CW:0]       f [3],
	output logic signed [2*CW+2:0]   n [3]
);
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int NW = PW + 1;

	logic signed [PW-1:0] pa_s2 [3];
	logic signed [PW-1:0] pb_s2 [3];
	logic signed [NW-1:0] n_s3  [3];

	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			pa_s2[0] <= PW'(e[1]) * PW'(f[2]);
			pb_s2[0] <= PW'(e[2]) * PW'(f[1]);
			pa_s2[1] <= PW'(e[2]) * PW'(f[0]);
			pb_s2[1] <= PW'(e[0]) * PW'(f[2]);
			pa_s2[2] <= PW'(e[0]) * PW'(f[1]);
			pb_s2[2] <= PW'(e[1]) * PW'(f[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			for (int k = 0; k < 3; k++) begin
				n_s3[k] <= NW'(pa_s2[k]) - NW'(pb_s2[k]);
			end
		end
	end

	assign n = n_s3;

endmodule

// ===== hdl/tbot_edge.sv =====
// Edge-function tests of one 2D projection, one per triangle edge, plain and flipped normals.
// Depends on tbot_pkg.
module tbot_edge #(
	parameter int CW = tbot_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  tbot_pkg::tbot_ld_t                   ld,
	input  logic signed [CW:0]                   eu [3],
	input  logic signed [CW:0]                   ew [3],
	input  logic signed [CW:0]                   au [3],
	input  logic signed [CW:0]                   aw [3],
	input  logic signed [tbot_pkg::DSIGNED_W-1:0] du,
	input  logic signed [tbot_pkg::DSIGNED_W-1:0] dw,
	output logic                                 pass_plain,
	output logic                                 pass_flip
);
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int DMW = tbot_pkg::DSIGNED_W + DW;
	localparam int EW  = ((PW > DMW) ? PW : DMW) + 3;

	logic signed [PW-1:0]  pa_s2 [3];
	logic signed [PW-1:0]  pb_s2 [3];
	logic signed [DMW-1:0] qu_s2 [3];
	logic signed [DMW-1:0] qw_s2 [3];
	logic                  plain_s3;
	logic                  flip_s3;
	logic [2:0]            ok_p;
	logic [2:0]            ok_f;

	// edge normal m = (-ew, eu); products taken for the unflipped sign
	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= -(PW'(ew[i]) * PW'(au[i]));
				pb_s2[i] <= PW'(eu[i]) * PW'(aw[i]);
				qu_s2[i] <= -(DMW'(du) * DMW'(ew[i]));
				qw_s2[i] <= DMW'(dw) * DMW'(eu[i]);
			end
		end
	end

	always_comb begin
		logic signed [EW-1:0] a;
		logic signed [EW-1:0] xu;
		logic signed [EW-1:0] xw;
		logic signed [EW-1:0] tp;
		logic signed [EW-1:0] tn;
		for (int i = 0; i < 3; i++) begin
			a  = EW'(pa_s2[i]) + EW'(pb_s2[i]);
			xu = EW'(qu_s2[i]);
			xw = EW'(qw_s2[i]);
			tp = a + (xu[EW-1] ? '0 : xu) + (xw[EW-1] ? '0 : xw);
			tn = -a + (xu[EW-1] ? -xu : '0) + (xw[EW-1] ? -xw : '0);
			ok_p[i] = !tp[EW-1];
			ok_f[i] = !tn[EW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			plain_s3 <= &ok_p;
			flip_s3  <= &ok_f;
		end
	end

	assign pass_plain = plain_s3;
	assign pass_flip  = flip_s3;

endmodule

// ===== hdl/tbot_plane.sv =====
// Plane test: critical-corner offsets times the normal, then the sign check.
// Depends on tbot_pkg.
module tbot_plane #(
	parameter int CW = tbot_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  tbot_pkg::tbot_ld_t                   ld,
	input  logic signed [2*CW+2:0]               n    [3],
	input  logic signed [CW:0]                   base [3],
	input  logic signed [tbot_pkg::DSIGNED_W-1:0] d    [3],
	output logic                                 separated
);
	localparam int DW  = CW + 1;
	localparam int NW  = 2 * DW + 1;
	localparam int BW  = ((DW > tbot_pkg::DSIGNED_W) ? DW : tbot_pkg::DSIGNED_W) + 1;
	localparam int SPW = NW + BW;
	localparam int SW  = SPW + 2;

	logic signed [SPW-1:0] p1_s4 [3];
	logic signed [SPW-1:0] p2_s4 [3];
	logic signed [SW-1:0]  sum1;
	logic signed [SW-1:0]  sum2;

	always_ff @(posedge clk) begin
		logic signed [BW-1:0] c;
		if (ld.ld_s4) begin
			for (int k = 0; k < 3; k++) begin
				c = (!n[k][NW-1] && (n[k] != '0)) ? BW'(d[k]) : '0;
				p1_s4[k] <= SPW'(n[k]) * SPW'(BW'(base[k]) + c);
				p2_s4[k] <= SPW'(n[k]) * SPW'(BW'(base[k]) + BW'(d[k]) - c);
			end
		end
	end

	assign sum1 = SW'(p1_s4[0]) + SW'(p1_s4[1]) + SW'(p1_s4[2]);
	assign sum2 = SW'(p2_s4[0]) + SW'(p2_s4[1]) + SW'(p2_s4[2]);

	// both offsets strictly on one side of the plane
	assign separated = (sum1 != '0) && (sum2 != '0) && (sum1[SW-1] == sum2[SW-1]);

endmodule

// ===== hdl/triangle_box_overlap_test_core.sv =====
// Triangle / axis-aligned box overlap test, five register stages deep.
// Depends on tbot_pkg, tbot_cross, tbot_edge, tbot_plane.
//
// One triangle/box pair is accepted per clock while in_stall is low, and its
// overlaps word passes through input differences (s1), products of the normal
// and all the edge functions (s2), normal and edge signs (s3), plane offset
// products (s4), and the output register. Each stage has its own valid bit
// and loads whenever it is empty or its successor loads, so bubbles collapse
// and a stalled output holds only as much of the pipeline as is full. The box
// extent comes from three 15-bit registers written through the config
// channel, which is always ready; write them only while no word is in flight.
// All arithmetic is exact integer math; a value of exactly zero counts as
// touching and therefore overlapping.
module triangle_box_overlap_test_core #(
	parameter int COORD_WIDTH = tbot_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COORD_WIDTH-1:0]     vertex0_x,
	input  logic signed [COORD_WIDTH-1:0]     vertex0_y,
	input  logic signed [COORD_WIDTH-1:0]     vertex0_z,
	input  logic signed [COORD_WIDTH-1:0]     vertex1_x,
	input  logic signed [COORD_WIDTH-1:0]     vertex1_y,
	input  logic signed [COORD_WIDTH-1:0]     vertex1_z,
	input  logic signed [COORD_WIDTH-1:0]     vertex2_x,
	input  logic signed [COORD_WIDTH-1:0]     vertex2_y,
	input  logic signed [COORD_WIDTH-1:0]     vertex2_z,
	input  logic signed [COORD_WIDTH-1:0]     box_min_x,
	input  logic signed [COORD_WIDTH-1:0]     box_min_y,
	input  logic signed [COORD_WIDTH-1:0]     box_min_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              overlaps,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tbot_pkg::INDEX_W-1:0]      cfg_index,
	input  logic [tbot_pkg::SIZE_W-1:0]       cfg_data
);
	localparam int DW = COORD_WIDTH + 1;
	localparam int NW = 2 * DW + 1;

	// config registers
	logic [tbot_pkg::SIZE_W-1:0]             size_q [3];
	logic signed [tbot_pkg::DSIGNED_W-1:0]   dsz    [3];

	// pipeline control
	logic               valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic               ld_s1, ld_out;
	tbot_pkg::tbot_ld_t ld;

	// stage data
	logic signed [COORD_WIDTH-1:0] vert [3][3];
	logic signed [COORD_WIDTH-1:0] pmin [3];
	logic signed [DW-1:0] edg_s1 [3][3];
	logic signed [DW-1:0] pv_s1  [3][3];
	logic signed [DW-1:0] f_s1   [3];
	logic signed [DW-1:0] base_s2 [3];
	logic signed [DW-1:0] base_s3 [3];
	logic signed [NW-1:0] n_s3   [3];
	logic                 edge_ok_s4;
	logic                 overlaps_q;
	logic                 plane_sep;

	logic [2:0] pass_plain;
	logic [2:0] pass_flip;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				size_q[k] <= tbot_pkg::SIZE_W'(1);
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tbot_pkg::REG_BOX_SIZE_X: size_q[0] <= cfg_data;
				tbot_pkg::REG_BOX_SIZE_Y: size_q[1] <= cfg_data;
				tbot_pkg::REG_BOX_SIZE_Z: size_q[2] <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dsz[k] = $signed({1'b0, size_q[k]});
		end
	end

	// a stage loads when it is empty or its contents move on
	assign ld_out   = !out_valid_q || !out_stall;
	assign ld.ld_s4 = !valid_s4 || ld_out;
	assign ld.ld_s3 = !valid_s3 || ld.ld_s4;
	assign ld.ld_s2 = !valid_s2 || ld.ld_s3;
	assign ld_s1    = !valid_s1 || ld.ld_s2;
	assign in_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1)    valid_s1    <= in_valid;
			if (ld.ld_s2) valid_s2    <= valid_s1;
			if (ld.ld_s3) valid_s3    <= valid_s2;
			if (ld.ld_s4) valid_s4    <= valid_s3;
			if (ld_out)   out_valid_q <= valid_s4;
		end
	end

	assign vert[0][0] = vertex0_x;
	assign vert[0][1] = vertex0_y;
	assign vert[0][2] = vertex0_z;
	assign vert[1][0] = vertex1_x;
	assign vert[1][1] = vertex1_y;
	assign vert[1][2] = vertex1_z;
	assign vert[2][0] = vertex2_x;
	assign vert[2][1] = vertex2_y;
	assign vert[2][2] = vertex2_z;
	assign pmin[0]    = box_min_x;
	assign pmin[1]    = box_min_y;
	assign pmin[2]    = box_min_z;

	// s1: edge vectors v[i+1]-v[i], f = v2-v0, and box corner relative to each vertex
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					edg_s1[i][k] <= DW'(vert[(i + 1) % 3][k]) - DW'(vert[i][k]);
					pv_s1[i][k]  <= DW'(pmin[k]) - DW'(vert[i][k]);
				end
			end
			for (int k = 0; k < 3; k++) begin
				f_s1[k] <= DW'(vert[2][k]) - DW'(vert[0][k]);
			end
		end
	end

	// carry p - v0 along to the plane stage
	always_ff @(posedge clk) begin
		if (ld.ld_s2) base_s2 <= pv_s1[0];
		if (ld.ld_s3) base_s3 <= base_s2;
	end

	tbot_cross #(.CW(COORD_WIDTH)) u_cross (
		.clk (clk),
		.ld  (ld),
		.e   (edg_s1[0]),
		.f   (f_s1),
		.n   (n_s3)
	);

	// projections: 0 = XY, 1 = XZ, 2 = YZ
	for (genvar g = 0; g < 3; g++) begin : g_proj
		localparam int U = (g == 2) ? 1 : 0;
		localparam int W = (g == 0) ? 1 : 2;
		logic signed [DW-1:0] eu [3];
		logic signed [DW-1:0] ew [3];
		logic signed [DW-1:0] au [3];
		logic signed [DW-1:0] aw [3];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				eu[i] = edg_s1[i][U];
				ew[i] = edg_s1[i][W];
				au[i] = pv_s1[i][U];
				aw[i] = pv_s1[i][W];
			end
		end

		tbot_edge #(.CW(COORD_WIDTH)) u_edge (
			.clk        (clk),
			.ld         (ld),
			.eu         (eu),
			.ew         (ew),
			.au         (au),
			.aw         (aw),
			.du         (dsz[U]),
			.dw         (dsz[W]),
			.pass_plain (pass_plain[g]),
			.pass_flip  (pass_flip[g])
		);
	end

	// s4: pick flipped or plain edge results by the normal's signs
	always_ff @(posedge clk) begin
		if (ld.ld_s4) begin
			edge_ok_s4 <= (n_s3[2][NW-1]  ? pass_flip[0] : pass_plain[0]) &&
			              (!n_s3[1][NW-1] ? pass_flip[1] : pass_plain[1]) &&
			              (n_s3[0][NW-1]  ? pass_flip[2] : pass_plain[2]);
		end
	end

	tbot_plane #(.CW(COORD_WIDTH)) u_plane (
		.clk       (clk),
		.ld        (ld),
		.n         (n_s3),
		.base      (base_s3),
		.d         (dsz),
		.separated (plane_sep)
	);

	always_ff @(posedge clk) begin
		if (ld_out) overlaps_q <= edge_ok_s4 && !plane_sep;
	end

	assign out_valid = out_valid_q;
	assign overlaps  = overlaps_q;

	// a completely full pipeline with a stalled output must stall the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_valid_q && out_stall)
		|-> in_stall)
		else $error("pipeline full but input not stalled");

	// an empty output register never holds back the input
	a_empty_flows: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled with empty output register");

	// a word leaving s3 must land in s4
	a_s4_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(ld.ld_s4 && valid_s3) |=> valid_s4)
		else $error("word lost between s3 and s4");

endmodule
